// File: rtl/core/mqd_pkg.sv
// Shared types and constants for the multilevel queue dispatcher.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
package mqd_pkg;

   localparam int DEF_MAX_JOBS   = 64;
   localparam int DEF_TIME_WIDTH = 16;

   localparam int NUM_QUEUES  = 5;
   localparam int QID_W       = 3;
   localparam int FIELD_W     = 16;
   localparam int SLICE_W     = 16;
   localparam int QUANTUM_W   = 16;
   localparam int TIMER_W     = 23;
   localparam int OUT_SLOT_W  = 6;
   localparam int PRIO_W      = 2;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(1);

   localparam logic [PRIO_W-1:0] PRIO_REALTIME = 2'd0;
   localparam logic [PRIO_W-1:0] PRIO_NORMAL   = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_DEMOTED  = 2'd2;

   localparam logic CMD_LOAD = 1'b0;

   typedef enum logic [QID_W-1:0] {
      Q_RTWAIT = 3'd0,
      Q_NWAIT  = 3'd1,
      Q_L0     = 3'd2,
      Q_L1     = 3'd3,
      Q_L2     = 3'd4
   } qid_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAIN_QRD,
      ST_DRAIN_JRD,
      ST_DRAIN_CMP,
      ST_CHG_RD,
      ST_CHG,
      ST_PICK_RD,
      ST_PICK_JRD,
      ST_PICK_J,
      ST_SLICE
   } state_type;

endpackage

// File: rtl/core/multilevel_queue_dispatcher_top.sv
// Multilevel queue dispatcher: a load transaction gives its result on the next cycle.
// A step transaction holds busy while the sequencer moves each arrived job from a waiting queue,
// updates the running job, picks the next one and sets the slice, sharing one job table read port.
// busy stays high while a step runs; the result strobe lasts one cycle, no stall.
// Synchronous active-high reset empties all queues, clears the timer, quantum = 1.
// Depends on mqd_pkg, mqd_job_ram, mqd_queue_ram.
`timescale 1ns / 1ps
module multilevel_queue_dispatcher_top
   import mqd_pkg::*;
#(
   parameter int MAX_JOBS   = DEF_MAX_JOBS,
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [FIELD_W-1:0]    req_arrival_time,
   input  logic [FIELD_W-1:0]    req_service_time,
   input  logic [PRIO_W-1:0]     req_job_priority,
   input  logic                  csr_we,
   input  logic [QUANTUM_W-1:0]  csr_wdata,
   output logic                  rsp_valid,
   output logic                  rsp_accepted,
   output logic [OUT_SLOT_W-1:0] rsp_assigned_job,
   output logic                  rsp_running_valid,
   output logic [OUT_SLOT_W-1:0] rsp_running_job,
   output logic                  rsp_resumed,
   output logic [SLICE_W-1:0]    rsp_slice,
   output logic [TIMER_W-1:0]    rsp_timer_now,
   output logic                  rsp_finished_valid,
   output logic [OUT_SLOT_W-1:0] rsp_finished_job,
   output logic [TIMER_W-1:0]    rsp_finish_time,
   output logic                  rsp_all_done
);

   localparam int TW      = TIME_WIDTH;
   localparam int SLOT_W  = $clog2(MAX_JOBS);
   localparam int CNT_W   = $clog2(MAX_JOBS + 1);
   localparam int SUM_W   = SLOT_W + 2;
   localparam int CMP_W   = (TW > TIMER_W) ? TW : TIMER_W;
   localparam int ENTRY_W = 2 * TW + PRIO_W + 1;

   // state
   state_type                 state_ff, state_in;
   qid_type                   drain_q_ff, drain_q_in;
   qid_type                   pick_q_ff, pick_q_in;
   logic [CNT_W-1:0]          cnt_ff [NUM_QUEUES];
   logic [CNT_W-1:0]          cnt_in [NUM_QUEUES];
   logic [SLOT_W-1:0]         head_ff [NUM_QUEUES];
   logic [SLOT_W-1:0]         head_in [NUM_QUEUES];
   logic [CNT_W-1:0]          loaded_ff, loaded_in;
   logic [SLOT_W-1:0]         cur_slot_ff, cur_slot_in;
   logic                      cur_valid_ff, cur_valid_in;
   logic [TW-1:0]             cur_rem_ff, cur_rem_in;
   logic [PRIO_W-1:0]         cur_prio_ff, cur_prio_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [SLICE_W-1:0]        last_slice_ff, last_slice_in;
   logic [TIMER_W-1:0]        timer_ff, timer_in;
   logic [QUANTUM_W-1:0]      quantum_ff;

   // result
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accepted_ff, accepted_in;
   logic [OUT_SLOT_W-1:0]     assigned_ff, assigned_in;
   logic                      resumed_ff, resumed_in;
   logic [SLICE_W-1:0]        rslice_ff, rslice_in;
   logic                      fin_valid_ff, fin_valid_in;
   logic [OUT_SLOT_W-1:0]     fin_job_ff, fin_job_in;
   logic [TIMER_W-1:0]        fin_time_ff, fin_time_in;

   // memory ports
   logic                      job_we, job_re;
   logic [SLOT_W-1:0]         job_waddr, job_raddr;
   logic [ENTRY_W-1:0]        job_wdata, job_rdata;
   logic                      q_we, q_re;
   qid_type                   q_wq, q_rq;
   logic [SLOT_W-1:0]         q_widx, q_ridx, q_wdata, q_rdata;

   // unpacked read entry
   logic [TW-1:0]             rd_arr, rd_rem;
   logic [PRIO_W-1:0]         rd_prio;
   logic                      rd_susp;
   logic [TW-1:0]             new_rem;
   logic [PRIO_W-1:0]         new_prio;
   logic [SLICE_W-1:0]        slice_val;
   logic [TIMER_W:0]          timer_sum;
   logic                      any_ready, any_wait;

   assign rd_arr  = job_rdata[ENTRY_W-1 -: TW];
   assign rd_rem  = job_rdata[TW+PRIO_W : PRIO_W+1];
   assign rd_prio = job_rdata[PRIO_W:1];
   assign rd_susp = job_rdata[0];
   assign new_rem = TW'(rd_rem - TW'(last_slice_ff));
   assign new_prio = (rd_prio == PRIO_NORMAL) ? PRIO_DEMOTED : rd_prio;
   assign any_ready = (cnt_ff[Q_L0] != '0) || (cnt_ff[Q_L1] != '0);
   assign any_wait  = (cnt_ff[Q_RTWAIT] != '0) || (cnt_ff[Q_NWAIT] != '0);

   function automatic logic [SLOT_W-1:0] idx_inc(input logic [SLOT_W-1:0] idx);
      return (SUM_W'(idx) == SUM_W'(MAX_JOBS - 1)) ? '0 : SLOT_W'(idx + 1'b1);
   endfunction

   function automatic logic [SLOT_W-1:0] idx_dec(input logic [SLOT_W-1:0] idx);
      return (idx == '0) ? SLOT_W'(MAX_JOBS - 1) : SLOT_W'(idx - 1'b1);
   endfunction

   function automatic logic [SLOT_W-1:0] idx_tail(input logic [SLOT_W-1:0] head,
                                                  input logic [CNT_W-1:0]  cnt);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(cnt);
      if (sum >= SUM_W'(MAX_JOBS)) begin
         sum = sum - SUM_W'(MAX_JOBS);
      end
      return SLOT_W'(sum);
   endfunction

   // slice for the job holding the processor; one while only waiting jobs exist, else zero
   always_comb begin
      if (cur_valid_ff) begin
         unique case (cur_prio_ff)
            PRIO_REALTIME: slice_val = SLICE_W'(cur_rem_ff);
            PRIO_NORMAL: begin
               if (CMP_W'(quantum_ff) < CMP_W'(cur_rem_ff)) begin
                  slice_val = SLICE_W'(quantum_ff);
               end else begin
                  slice_val = SLICE_W'(cur_rem_ff);
               end
            end
            default: slice_val = SLICE_W'(1);
         endcase
      end else if (any_wait) begin
         slice_val = SLICE_W'(1);
      end else begin
         slice_val = '0;
      end
   end

   assign timer_sum = {1'b0, timer_ff} + (TIMER_W + 1)'(slice_val);

   // sequencer: next state, memory ports and result
   always_comb begin
      state_in      = state_ff;
      drain_q_in    = drain_q_ff;
      pick_q_in     = pick_q_ff;
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      loaded_in     = loaded_ff;
      cur_slot_in   = cur_slot_ff;
      cur_valid_in  = cur_valid_ff;
      cur_rem_in    = cur_rem_ff;
      cur_prio_in   = cur_prio_ff;
      slot_in       = slot_ff;
      last_slice_in = last_slice_ff;
      timer_in      = timer_ff;
      rsp_valid_in  = 1'b0;
      accepted_in   = accepted_ff;
      assigned_in   = assigned_ff;
      resumed_in    = resumed_ff;
      rslice_in     = rslice_ff;
      fin_valid_in  = fin_valid_ff;
      fin_job_in    = fin_job_ff;
      fin_time_in   = fin_time_ff;
      job_we        = 1'b0;
      job_waddr     = '0;
      job_wdata     = '0;
      job_re        = 1'b0;
      job_raddr     = '0;
      q_we          = 1'b0;
      q_wq          = Q_RTWAIT;
      q_widx        = '0;
      q_wdata       = '0;
      q_re          = 1'b0;
      q_rq          = Q_RTWAIT;
      q_ridx        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               accepted_in  = 1'b0;
               assigned_in  = '0;
               resumed_in   = 1'b0;
               rslice_in    = '0;
               fin_valid_in = 1'b0;
               fin_job_in   = '0;
               fin_time_in  = '0;
               if (req_command == CMD_LOAD) begin
                  rsp_valid_in = 1'b1;
                  if (req_job_priority <= PRIO_NORMAL && loaded_ff < CNT_W'(MAX_JOBS)) begin
                     // store the job and append it to its waiting queue
                     job_we    = 1'b1;
                     job_waddr = SLOT_W'(loaded_ff);
                     job_wdata = {TW'(req_arrival_time), TW'(req_service_time),
                                  req_job_priority, 1'b0};
                     q_we      = 1'b1;
                     q_wq      = (req_job_priority == PRIO_REALTIME) ? Q_RTWAIT : Q_NWAIT;
                     q_widx    = idx_tail(head_ff[q_wq], cnt_ff[q_wq]);
                     q_wdata   = SLOT_W'(loaded_ff);
                     cnt_in[q_wq] = cnt_ff[q_wq] + 1'b1;
                     loaded_in    = loaded_ff + 1'b1;
                     accepted_in  = 1'b1;
                     assigned_in  = OUT_SLOT_W'(loaded_ff);
                  end
               end else begin
                  drain_q_in = Q_RTWAIT;
                  state_in   = ST_DRAIN_QRD;
               end
            end
         end

         ST_DRAIN_QRD: begin
            if (cnt_ff[drain_q_ff] != '0) begin
               q_re     = 1'b1;
               q_rq     = drain_q_ff;
               q_ridx   = head_ff[drain_q_ff];
               state_in = ST_DRAIN_JRD;
            end else if (drain_q_ff == Q_RTWAIT) begin
               drain_q_in = Q_NWAIT;
            end else begin
               state_in = ST_CHG_RD;
            end
         end

         ST_DRAIN_JRD: begin
            slot_in   = q_rdata;
            job_re    = 1'b1;
            job_raddr = q_rdata;
            state_in  = ST_DRAIN_CMP;
         end

         ST_DRAIN_CMP: begin
            if (CMP_W'(rd_arr) <= CMP_W'(timer_ff)) begin
               // move the arrived job to its ready level
               head_in[drain_q_ff] = idx_inc(head_ff[drain_q_ff]);
               cnt_in[drain_q_ff]  = cnt_ff[drain_q_ff] - 1'b1;
               q_we    = 1'b1;
               q_wq    = (drain_q_ff == Q_RTWAIT) ? Q_L0 : Q_L1;
               q_widx  = idx_tail(head_ff[q_wq], cnt_ff[q_wq]);
               q_wdata = slot_ff;
               cnt_in[q_wq] = cnt_ff[q_wq] + 1'b1;
               state_in = ST_DRAIN_QRD;
            end else if (drain_q_ff == Q_RTWAIT) begin
               drain_q_in = Q_NWAIT;
               state_in   = ST_DRAIN_QRD;
            end else begin
               state_in = ST_CHG_RD;
            end
         end

         ST_CHG_RD: begin
            if (cur_valid_ff) begin
               job_re    = 1'b1;
               job_raddr = cur_slot_ff;
               state_in  = ST_CHG;
            end else begin
               state_in = ST_PICK_RD;
            end
         end

         ST_CHG: begin
            job_we    = 1'b1;
            job_waddr = cur_slot_ff;
            if (CMP_W'(last_slice_ff) >= CMP_W'(rd_rem)) begin
               // job completes
               job_wdata    = {rd_arr, TW'(0), rd_prio, rd_susp};
               fin_valid_in = 1'b1;
               fin_job_in   = OUT_SLOT_W'(cur_slot_ff);
               fin_time_in  = timer_ff;
               cur_valid_in = 1'b0;
            end else if (any_ready || rd_prio == PRIO_NORMAL) begin
               // suspend into level two
               job_wdata    = {rd_arr, new_rem, new_prio, 1'b1};
               cur_valid_in = 1'b0;
               q_we         = 1'b1;
               q_wq         = Q_L2;
               q_wdata      = cur_slot_ff;
               cnt_in[Q_L2] = cnt_ff[Q_L2] + 1'b1;
               if (rd_prio == PRIO_NORMAL) begin
                  q_widx = idx_tail(head_ff[Q_L2], cnt_ff[Q_L2]);
               end else begin
                  q_widx        = idx_dec(head_ff[Q_L2]);
                  head_in[Q_L2] = idx_dec(head_ff[Q_L2]);
               end
            end else begin
               // keep running
               job_wdata   = {rd_arr, new_rem, rd_prio, rd_susp};
               cur_rem_in  = new_rem;
               cur_prio_in = rd_prio;
            end
            state_in = ST_PICK_RD;
         end

         ST_PICK_RD: begin
            if (!cur_valid_ff && (any_ready || cnt_ff[Q_L2] != '0)) begin
               priority if (cnt_ff[Q_L0] != '0) pick_q_in = Q_L0;
               else if (cnt_ff[Q_L1] != '0)    pick_q_in = Q_L1;
               else                             pick_q_in = Q_L2;
               q_re     = 1'b1;
               q_rq     = pick_q_in;
               q_ridx   = head_ff[pick_q_in];
               state_in = ST_PICK_JRD;
            end else begin
               state_in = ST_SLICE;
            end
         end

         ST_PICK_JRD: begin
            slot_in   = q_rdata;
            job_re    = 1'b1;
            job_raddr = q_rdata;
            head_in[pick_q_ff] = idx_inc(head_ff[pick_q_ff]);
            cnt_in[pick_q_ff]  = cnt_ff[pick_q_ff] - 1'b1;
            state_in  = ST_PICK_J;
         end

         ST_PICK_J: begin
            resumed_in   = rd_susp;
            job_we       = 1'b1;
            job_waddr    = slot_ff;
            job_wdata    = {rd_arr, rd_rem, rd_prio, 1'b0};
            cur_slot_in  = slot_ff;
            cur_valid_in = 1'b1;
            cur_rem_in   = rd_rem;
            cur_prio_in  = rd_prio;
            state_in     = ST_SLICE;
         end

         ST_SLICE: begin
            last_slice_in = slice_val;
            rslice_in     = slice_val;
            timer_in      = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         drain_q_ff    <= Q_RTWAIT;
         pick_q_ff     <= Q_L0;
         cnt_ff        <= '{default: '0};
         head_ff       <= '{default: '0};
         loaded_ff     <= '0;
         cur_slot_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         last_slice_ff <= '0;
         timer_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         drain_q_ff    <= drain_q_in;
         pick_q_ff     <= pick_q_in;
         cnt_ff        <= cnt_in;
         head_ff       <= head_in;
         loaded_ff     <= loaded_in;
         cur_slot_ff   <= cur_slot_in;
         cur_valid_ff  <= cur_valid_in;
         last_slice_ff <= last_slice_in;
         timer_ff      <= timer_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // quantum register
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_we) begin
         quantum_ff <= csr_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_rem_ff  <= cur_rem_in;
      cur_prio_ff <= cur_prio_in;
      slot_ff     <= slot_in;
      accepted_ff <= accepted_in;
      assigned_ff <= assigned_in;
      resumed_ff  <= resumed_in;
      rslice_ff   <= rslice_in;
      fin_valid_ff <= fin_valid_in;
      fin_job_ff  <= fin_job_in;
      fin_time_ff <= fin_time_in;
   end

   mqd_job_ram #(
      .DEPTH (MAX_JOBS),
      .AW    (SLOT_W),
      .DW    (ENTRY_W)
   ) u_job_ram (
      .clock (clock),
      .we    (job_we),
      .waddr (job_waddr),
      .wdata (job_wdata),
      .re    (job_re),
      .raddr (job_raddr),
      .rdata (job_rdata)
   );

   mqd_queue_ram #(
      .DEPTH (MAX_JOBS),
      .AW    (SLOT_W)
   ) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .wq    (q_wq),
      .widx  (q_widx),
      .wdata (q_wdata),
      .re    (q_re),
      .rq    (q_rq),
      .ridx  (q_ridx),
      .rdata (q_rdata)
   );

   // drive ports
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = accepted_ff;
   assign rsp_assigned_job   = assigned_ff;
   assign rsp_running_valid  = cur_valid_ff;
   assign rsp_running_job    = cur_valid_ff ? OUT_SLOT_W'(cur_slot_ff) : '0;
   assign rsp_resumed        = resumed_ff;
   assign rsp_slice          = rslice_ff;
   assign rsp_timer_now      = timer_ff;
   assign rsp_finished_valid = fin_valid_ff;
   assign rsp_finished_job   = fin_job_ff;
   assign rsp_finish_time    = fin_time_ff;
   assign rsp_all_done       = !cur_valid_ff && !any_ready && !any_wait
                               && (cnt_ff[Q_L2] == '0);

endmodule

// File: rtl/core/mqd_job_ram.sv
// Job table memory: one write port, one registered read port.
// Depends on mqd_pkg for the default depth.
`timescale 1ns / 1ps
module mqd_job_ram
   import mqd_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_JOBS,
   parameter int AW    = 6,
   parameter int DW    = 35
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   // write entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/mqd_queue_ram.sv
// Slot storage for the five circular queues, one row per queue.
// Depends on mqd_pkg for the queue id type, the queue count and the default depth.
`timescale 1ns / 1ps
module mqd_queue_ram
   import mqd_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_JOBS,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  qid_type       wq,
   input  logic [AW-1:0] widx,
   input  logic [AW-1:0] wdata,
   input  logic          re,
   input  qid_type       rq,
   input  logic [AW-1:0] ridx,
   output logic [AW-1:0] rdata
);

   logic [AW-1:0] mem [NUM_QUEUES][DEPTH];
   logic [AW-1:0] rdata_ff;

   // write slot
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wq][widx] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[rq][ridx];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/mqd_checker.sv
// Port-level checks for the multilevel queue dispatcher, bound to the top level.
// Depends on mqd_pkg and multilevel_queue_dispatcher_top.
`timescale 1ns / 1ps
module mqd_checker
   import mqd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_command,
   input logic               rsp_valid,
   input logic               rsp_running_valid,
   input logic               rsp_finished_valid,
   input logic [TIMER_W-1:0] rsp_finish_time,
   input logic [TIMER_W-1:0] rsp_timer_now,
   input logic               rsp_all_done
);

   // a load transaction answers on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_LOAD |=> rsp_valid)
      else $error("load transaction without a result on the next cycle");

   // results only show while the dispatcher is free
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // busy only starts from an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without start");

   // a completion never lies after the current time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished_valid |-> rsp_finish_time <= rsp_timer_now)
      else $error("finish time beyond timer");

   // all done means nothing holds the processor
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_done |-> !rsp_running_valid)
      else $error("all done with a running job");

endmodule

bind multilevel_queue_dispatcher_top mqd_checker u_mqd_checker (.*);
